// ===== rtl/core/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the sorted table search
// Field widths, opcodes, controller states and controller/datapath bundles.
// ----------------------------------------------------------------------------
package sts_pkg;

   // Fixed payload widths
   localparam int VALUE_W = 64;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;

   // Request opcodes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // Controller states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_PROBE   = 4'b0010,
      ST_COMPARE = 4'b0100,
      ST_FINISH  = 4'b1000
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic write;     // store request value into the table
      logic start;     // load bounds and target for a search
      logic read;      // issue table read at the midpoint
      logic advance;   // narrow bounds or record a hit
      logic deliver;   // load the result register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic empty;     // low bound has reached high bound
      logic hit;       // probed entry equals target
      logic rsp_free;  // result register can take a new result
   } status_type;

endpackage

// ===== rtl/core/sts_if.sv =====
// ----------------------------------------------------------------------------
// sts_if: channel interfaces for the sorted table search
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sts_req_if;
   import sts_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic [INDEX_W-1:0]        entry_index;
   logic signed [VALUE_W-1:0] item_value;
   modport source (output valid, output opcode, output entry_index, output item_value,
                   input ready);
   modport sink (input valid, input opcode, input entry_index, input item_value,
                 output ready);
endinterface

interface sts_rsp_if;
   logic valid;
   logic ready;
   logic found;
   modport source (output valid, output found, input ready);
   modport sink (input valid, input found, output ready);
endinterface

interface sts_csr_if;
   import sts_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] entry_count;
   modport source (output valid, output entry_count, input ready);
   modport sink (input valid, input entry_count, output ready);
endinterface

// ===== rtl/core/sts_ram.sv =====
// ----------------------------------------------------------------------------
// sts_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sts_ctrl.sv =====
// ----------------------------------------------------------------------------
// sts_ctrl: search sequencer
// Accepts requests, steps the probe loop and hands results to the datapath.
// ----------------------------------------------------------------------------
module sts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_opcode,
   output logic                req_ready,
   input  sts_pkg::status_type status,
   output sts_pkg::cmd_type    cmd
);
   import sts_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_WRITE) begin
               cmd.write = 1'b1;
            end
            if (accept && req_opcode == OP_SEARCH) begin
               cmd.start = 1'b1;
               state_in  = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (status.empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.read = 1'b1;
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.advance = 1'b1;
            state_in    = status.hit ? ST_FINISH : ST_PROBE;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/sts_dp.sv =====
// ----------------------------------------------------------------------------
// sts_dp: search datapath
// Table memory, entry count register, search bounds, compare and result register.
// ----------------------------------------------------------------------------
module sts_dp #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sts_pkg::cmd_type                  cmd,
   output sts_pkg::status_type               status,
   input  logic [sts_pkg::INDEX_W-1:0]       req_entry_index,
   input  logic signed [sts_pkg::VALUE_W-1:0] req_item_value,
   input  logic                              csr_write,
   input  logic [sts_pkg::COUNT_W-1:0]       csr_entry_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_found
);
   import sts_pkg::*;

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int BOUND_W = $clog2(TABLE_DEPTH + 1);

   logic [COUNT_W-1:0] count_ff;
   logic [BOUND_W-1:0] low_ff, low_in;
   logic [BOUND_W-1:0] high_ff, high_in;
   logic [VALUE_W-1:0] target_ff;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff;
   logic [BOUND_W:0]   bound_sum;
   logic [BOUND_W-1:0] mid;
   logic [BOUND_W-1:0] mid_ff;
   logic [31:0]        index_wide;
   logic [31:0]        limit_wide;
   logic               wr_en;
   logic [VALUE_W-1:0] rd_data;
   logic               probe_less;

   // Table write: drop indexes beyond the table
   assign index_wide = 32'(req_entry_index);
   assign wr_en      = cmd.write && (index_wide < 32'(TABLE_DEPTH));

   // Midpoint of the current bounds
   assign bound_sum = {1'b0, low_ff} + {1'b0, high_ff};
   assign mid       = bound_sum[BOUND_W:1];

   sts_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (index_wide[ADDR_W-1:0]),
      .wr_data (req_item_value),
      .rd_en   (cmd.read),
      .rd_addr (mid[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Saturate the entry count to the table depth
   assign limit_wide = (32'(count_ff) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                          : 32'(count_ff);

   // Signed compare of the probed entry against the target
   assign probe_less = $signed(rd_data) < $signed(target_ff);

   assign status.empty    = !(low_ff < high_ff);
   assign status.hit      = (rd_data == target_ff);
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   // Bounds and hit flag
   always_comb begin
      low_in   = low_ff;
      high_in  = high_ff;
      found_in = found_ff;
      if (cmd.start) begin
         low_in   = '0;
         high_in  = limit_wide[BOUND_W-1:0];
         found_in = 1'b0;
      end else if (cmd.advance) begin
         if (status.hit) begin
            found_in = 1'b1;
         end else if (probe_less) begin
            low_in = mid_ff + BOUND_W'(1);
         end else begin
            high_in = mid_ff;
         end
      end
   end

   // Result register: load on deliver, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            count_ff <= csr_entry_count;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      high_ff  <= high_in;
      found_ff <= found_in;
      if (cmd.start) begin
         target_ff <= req_item_value;
      end
      if (cmd.read) begin
         mid_ff <= mid;
      end
      if (cmd.deliver) begin
         rsp_found_ff <= found_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

endmodule

// ===== rtl/core/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search: halving search over a sorted 64-bit table
// Stores signed entries on write requests and answers search requests.
// ----------------------------------------------------------------------------
//  channel | dir | payload                            | handshake
//  req     | in  | opcode, entry_index, item_value    | valid/ready
//  rsp     | out | found                              | valid/ready
//  csr     | in  | entry_count                        | valid/ready, always ready
//
// A search request steps through its probes: each reads the table at the
// midpoint (a registered read), then compares. It ends on a hit or when a
// bound check finds the range empty, and then loads the result register,
// waiting while a stalled response still holds that register.
// Reset clears the entry count and the result register; the table is not
// cleared. A stalled response holds only the finished search in its sequencer;
// write requests and a new search start while the response waits.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   sts_req_if.sink      req,
   sts_rsp_if.source    rsp,
   sts_csr_if.sink      csr
);
   import sts_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Register port never stalls
   assign csr.ready = 1'b1;

   sts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_opcode (req.opcode),
      .req_ready  (req.ready),
      .status     (status),
      .cmd        (cmd)
   );

   sts_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req.entry_index),
      .req_item_value  (req.item_value),
      .csr_write       (csr.valid && csr.ready),
      .csr_entry_count (csr.entry_count),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .rsp_found       (rsp.found)
   );

endmodule

// ===== rtl/core/sts_checker.sv =====
// ----------------------------------------------------------------------------
// sts_checker: port-level checks for the sorted table search
// Observes the top-level channels only; attached by bind.
// ----------------------------------------------------------------------------
module sts_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_opcode,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_found
);
   import sts_pkg::*;

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found))
      else $error("stalled response changed");

   // A search occupies the sequencer on the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OP_SEARCH |=> !req_ready)
      else $error("request taken during a search");

   // No response can appear right after a search is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OP_SEARCH |=> !$rose(rsp_valid))
      else $error("response too early after search");

endmodule

bind sorted_table_binary_search sts_checker u_sts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .req_opcode (req.opcode),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_found  (rsp.found)
);

// ===== bench/sorted_table_binary_search_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search_tb: self-checking bench for the table search
// Fills the table with sorted entries, sets the entry count and issues search
// requests. Each search answer is predicted from a bench copy of the table
// and compared in order. Idling varies by phase, including a long response
// hold-off and a full drain.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_tb;
   import sts_pkg::*;

   localparam int DEPTH         = 1024;
   localparam int LIMIT_CYCLES  = 500000;
   localparam int SETTLE_CYCLES = 32;
   localparam int LONG_HOLD     = 300;
   localparam int REPORT_MAX    = 10;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   // Table values kinds for fills
   localparam int FILL_WIDE   = 0;
   localparam int FILL_NARROW = 1;
   localparam int FILL_EDGES  = 2;

   // --------------------------------------------------------------------------
   // Search scoreboard: table copy, entry count and pending answers
   // --------------------------------------------------------------------------
   class search_scoreboard;
      logic signed [VALUE_W-1:0] entries [DEPTH];
      int unsigned               entry_count;
      bit                        answers [$];
      int                        errors;

      function new();
         entry_count = 0;
         errors      = 0;
      endfunction

      function int unsigned count_in_use();
         return (entry_count > DEPTH) ? DEPTH : entry_count;
      endfunction

      function void set_count(logic [COUNT_W-1:0] count);
         entry_count = 32'(count);
      endfunction

      // Halve the bounds until the target is met or the range is empty
      function bit search_hit(logic signed [VALUE_W-1:0] target);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         lo = 0;
         hi = count_in_use();
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (entries[mid] < target) begin
               lo = mid + 1;
            end else if (entries[mid] > target) begin
               hi = mid;
            end else begin
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      // Apply an accepted request: store a write, queue the answer of a search
      function void note_request(logic op, logic [INDEX_W-1:0] idx,
                                 logic signed [VALUE_W-1:0] value);
         if (op == OP_WRITE) begin
            if (idx < DEPTH) entries[idx] = value;
         end else begin
            answers.push_back(search_hit(value));
         end
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= REPORT_MAX) $display("%s", msg);
      endfunction

      function void check_found(logic found);
         bit want;
         if (answers.size() == 0) begin
            report($sformatf("unexpected response: found=%b", found));
         end else begin
            want = answers.pop_front();
            if (found !== want)
               report($sformatf("found mismatch: expected %b, actual %b", want, found));
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   sts_req_if req_if ();
   sts_rsp_if rsp_if ();
   sts_csr_if csr_if ();

   sorted_table_binary_search #(
      .TABLE_DEPTH(DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if),
      .csr  (csr_if)
   );

   search_scoreboard sb;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int filled_prefix  = 0;
   int cycles         = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Drive response ready; a pending hold-off overrides the random stalls
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         sb.check_found(rsp_if.found);
   end

   // Stop a hung run
   initial begin
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL sorted_table_binary_search");
      $finish;
   end

   function automatic logic signed [VALUE_W-1:0] random_wide();
      return {$urandom, $urandom};
   endfunction

   // Offer one request after random idle cycles and hold it until accepted
   task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx,
                               input logic signed [VALUE_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid       = 1'b1;
      req_if.opcode      = op;
      req_if.entry_index = idx;
      req_if.item_value  = value;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_request(op, idx, value);
   endtask

   // Drop the request valid, wait for every answer, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (sb.answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry_count(input int count);
      wait_idle();
      @(negedge clock);
      csr_if.valid       = 1'b1;
      csr_if.entry_count = COUNT_W'(count);
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      sb.set_count(COUNT_W'(count));
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // Write n sorted values into entries 0..n-1, in either index order
   task automatic load_sorted_table(input int n, input int kind);
      longint vals [$];
      int     k;
      bit     downward;
      vals.delete();
      for (k = 0; k < n; k++) begin
         case (kind)
            FILL_NARROW: vals.push_back(longint'($urandom_range(0, 40)) - 20);
            FILL_EDGES: begin
               if (k == 0) vals.push_back(VALUE_MIN);
               else if (k == 1) vals.push_back(VALUE_MAX);
               else vals.push_back(random_wide());
            end
            default: vals.push_back(random_wide());
         endcase
      end
      vals.sort();
      downward = 1'($urandom_range(0, 1));
      for (k = 0; k < n; k++) begin
         if (downward) send_request(OP_WRITE, INDEX_W'(n - 1 - k), vals[n - 1 - k]);
         else send_request(OP_WRITE, INDEX_W'(k), vals[k]);
      end
      if (n > filled_prefix) filled_prefix = n;
   endtask

   // Mostly searches aimed at stored values and their neighbors, some noise
   task automatic run_search_burst(input int n_items, input int hold_at,
                                   input int pause_at);
      int                        k;
      int                        pick;
      int unsigned               used;
      logic signed [VALUE_W-1:0] target;
      for (k = 0; k < n_items; k++) begin
         if (k == hold_at) hold_left = LONG_HOLD;
         if (k == pause_at) wait_idle();
         used = sb.count_in_use();
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_request(OP_WRITE, INDEX_W'($urandom_range(0, DEPTH - 1)), random_wide());
         end else begin
            if (pick < 50 && used > 0)
               target = sb.entries[$urandom_range(0, used - 1)];
            else if (pick < 65 && used > 0)
               target = sb.entries[$urandom_range(0, used - 1)]
                        + ($urandom_range(0, 1) ? 64'sd1 : -64'sd1);
            else if (pick < 72)
               target = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
            else
               target = random_wide();
            send_request(OP_SEARCH, INDEX_W'($urandom_range(0, DEPTH - 1)), target);
         end
      end
   endtask

   initial begin
      int phase;
      int n;
      int kind;
      sb = new();
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.opcode      = OP_WRITE;
      req_if.entry_index = '0;
      req_if.item_value  = '0;
      csr_if.valid       = 1'b0;
      csr_if.entry_count = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty table answers not found
      write_entry_count(0);
      send_request(OP_SEARCH, '0, 64'sd0);
      send_request(OP_SEARCH, '1, VALUE_MIN);
      send_request(OP_SEARCH, '0, VALUE_MAX);

      // Small table spanning the whole value range
      send_request(OP_WRITE, 10'd0, VALUE_MIN);
      send_request(OP_WRITE, 10'd1, VALUE_MIN + 64'sd1);
      send_request(OP_WRITE, 10'd2, -64'sd1);
      send_request(OP_WRITE, 10'd3, 64'sd0);
      send_request(OP_WRITE, 10'd4, 64'sd1);
      send_request(OP_WRITE, 10'd5, 64'sd42);
      send_request(OP_WRITE, 10'd6, VALUE_MAX - 64'sd1);
      send_request(OP_WRITE, 10'd7, VALUE_MAX);
      filled_prefix = 8;
      write_entry_count(8);
      send_request(OP_SEARCH, '0, VALUE_MIN);
      send_request(OP_SEARCH, '0, VALUE_MAX);
      send_request(OP_SEARCH, '0, 64'sd0);
      send_request(OP_SEARCH, '0, -64'sd1);
      send_request(OP_SEARCH, '0, 64'sd42);
      send_request(OP_SEARCH, '0, 64'sd2);
      send_request(OP_SEARCH, '0, VALUE_MAX - 64'sd2);
      send_request(OP_SEARCH, '0, -64'sd2);

      // Single entry in use
      write_entry_count(1);
      send_request(OP_SEARCH, '0, VALUE_MIN);
      send_request(OP_SEARCH, '0, 64'sd0);

      // Unsorted table: the answer follows the probes
      send_request(OP_WRITE, 10'd3, VALUE_MAX);
      write_entry_count(8);
      send_request(OP_SEARCH, '0, 64'sd1);
      send_request(OP_SEARCH, '0, 64'sd0);
      send_request(OP_SEARCH, '0, VALUE_MAX);

      // Random phases, cycling through the idling modes
      for (phase = 0; phase < 8; phase++) begin
         wait_idle();
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         kind = $urandom_range(FILL_WIDE, FILL_EDGES);
         if (phase == 2) begin
            // Full table, then a count above the depth
            load_sorted_table(DEPTH, FILL_WIDE);
            write_entry_count(DEPTH);
            run_search_burst(40, -1, -1);
            write_entry_count('1);
            run_search_burst(30, -1, -1);
         end else begin
            n = (phase == 5) ? 2 : $urandom_range(1, 24);
            load_sorted_table(n, kind);
            write_entry_count(n);
            run_search_burst(40, (phase == 0) ? 10 : -1, (phase == 1) ? 20 : -1);
            // Switch the count mid-phase to an arbitrary safe value
            if (phase % 3 == 0) begin
               if (filled_prefix == DEPTH)
                  write_entry_count($urandom_range(0, (1 << COUNT_W) - 1));
               else
                  write_entry_count($urandom_range(0, filled_prefix));
               run_search_burst(15, -1, -1);
            end
         end
      end

      wait_idle();
      if (sb.errors == 0 && sb.answers.size() == 0) begin
         $display("PASS sorted_table_binary_search");
      end else begin
         $display("FAIL sorted_table_binary_search");
      end
      $finish;
   end

endmodule
